// File: rtl/core/mrmb_pkg.sv
// Package with the region map, address decoder and shared types of the memory bus.
`default_nettype none

package mrmb_pkg;

  localparam int unsigned MAIN_RAM_BYTES  = 4194304;
  localparam int unsigned WRAM_BYTES      = 32768;
  localparam int unsigned VRAM_BYTES      = 1048576;
  localparam int unsigned IO_BYTES        = 8192;
  localparam int unsigned PAL_OAM_BYTES   = 2048;
  localparam int unsigned LOW_BIOS_BYTES  = 16384;
  localparam int unsigned HIGH_BIOS_BYTES = 4096;

  localparam int unsigned BASE_MAIN  = 0;
  localparam int unsigned BASE_VRAM  = BASE_MAIN + MAIN_RAM_BYTES / 4;
  localparam int unsigned BASE_WRAM  = BASE_VRAM + VRAM_BYTES / 4;
  localparam int unsigned BASE_LBIOS = BASE_WRAM + WRAM_BYTES / 4;
  localparam int unsigned BASE_IO    = BASE_LBIOS + LOW_BIOS_BYTES / 4;
  localparam int unsigned BASE_HBIOS = BASE_IO + IO_BYTES / 4;
  localparam int unsigned BASE_PAL   = BASE_HBIOS + HIGH_BIOS_BYTES / 4;
  localparam int unsigned BASE_OAM   = BASE_PAL + PAL_OAM_BYTES / 4;
  localparam int unsigned TOTAL_ROWS = BASE_OAM + PAL_OAM_BYTES / 4;
  localparam int unsigned ROW_W      = $clog2(TOTAL_ROWS);

  localparam logic [15:0] HB_PREFIX = 16'hFFFF;
  localparam logic [31:0] KEY_ADDR  = 32'h04000130;

  localparam logic [3:0] NIB_MAIN = 4'h2;
  localparam logic [3:0] NIB_WRAM = 4'h3;
  localparam logic [3:0] NIB_IO   = 4'h4;
  localparam logic [3:0] NIB_PAL  = 4'h5;
  localparam logic [3:0] NIB_VRAM = 4'h6;
  localparam logic [3:0] NIB_OAM  = 4'h7;

  localparam logic [2:0] MODE_RD8   = 3'd0;
  localparam logic [2:0] MODE_RD16  = 3'd1;
  localparam logic [2:0] MODE_RD32  = 3'd2;
  localparam logic [2:0] MODE_WR8   = 3'd3;
  localparam logic [2:0] MODE_WR16  = 3'd4;
  localparam logic [2:0] MODE_WR32  = 3'd5;
  localparam logic [2:0] MODE_DMA16 = 3'd6;
  localparam logic [2:0] MODE_DMA32 = 3'd7;

  localparam int unsigned IN_TDATA_W = 168;

  typedef logic [ROW_W-1:0] row_t;

  typedef struct packed {
    logic hit;
    row_t row;
  } dec_t;

  typedef struct packed {
    logic        rd;
    logic        we;
    logic [3:0]  be;
    row_t        row;
    logic [31:0] data;
  } mem_req_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [31:0] dma_source;
    logic [31:0] dma_dest;
    logic [20:0] dma_count;
    logic [15:0] key_state;
  } item_t;

  function automatic dec_t decode(input logic [31:0] a);
    logic [27:0] m;
    logic [31:0] off;
    dec_t        d;
    m     = a[27:0];
    off   = 32'(m[23:0]);
    d.hit = 1'b1;
    d.row = '0;
    if (a[31:16] == HB_PREFIX && 32'(a[15:0]) < HIGH_BIOS_BYTES) begin
      d.row = ROW_W'(BASE_HBIOS + 32'(a[15:2]));
    end else begin
      unique case (m[27:24])
        NIB_MAIN: d.row = ROW_W'(BASE_MAIN + ((off % MAIN_RAM_BYTES) >> 2));
        NIB_WRAM: d.row = ROW_W'(BASE_WRAM + ((off % WRAM_BYTES) >> 2));
        NIB_IO:   d.row = ROW_W'(BASE_IO + ((off % IO_BYTES) >> 2));
        NIB_PAL:  d.row = ROW_W'(BASE_PAL + ((off % PAL_OAM_BYTES) >> 2));
        NIB_VRAM: d.row = ROW_W'(BASE_VRAM + ((off % VRAM_BYTES) >> 2));
        NIB_OAM:  d.row = ROW_W'(BASE_OAM + ((off % PAL_OAM_BYTES) >> 2));
        default: begin
          if (32'(m) < LOW_BIOS_BYTES) begin
            d.row = ROW_W'(BASE_LBIOS + (32'(m) >> 2));
          end else begin
            d.hit = 1'b0;
          end
        end
      endcase
    end
    return d;
  endfunction

  function automatic logic is_key_word(input logic [31:0] a);
    return a[31:2] == KEY_ADDR[31:2];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/mrmb_ram.sv
// Single-port word memory holding every region, with byte enables and registered read data.
`default_nettype none

module mrmb_ram
  import mrmb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire mem_req_t req_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem [TOTAL_ROWS];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      for (int i = 0; i < 4; i++) begin
        if (req_i.be[i]) begin
          mem[req_i.row][8*i +: 8] <= req_i.data[8*i +: 8];
        end
      end
    end
    if (req_i.rd) begin
      rdata_q <= mem[req_i.row];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/mrmb_seq.sv
// Access sequencer: clearing pass, single reads and writes, and the block-copy loop.
`default_nettype none

module mrmb_seq
  import mrmb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire item_t       item_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output logic [31:0]      res_data_o,
  output mem_req_t         mem_req_o,
  input  wire logic [31:0] mem_rdata_i
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RDATA = 3'd2;
  localparam logic [2:0] S_DRD   = 3'd3;
  localparam logic [2:0] S_DWR   = 3'd4;
  localparam logic [2:0] S_HOLD  = 3'd5;

  logic [2:0]  state_q, state_d;
  row_t        clr_q, clr_d;
  logic [2:0]  mode_q, mode_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] src_q, src_d;
  logic [31:0] dst_q, dst_d;
  logic [20:0] cnt_q, cnt_d;
  logic [15:0] keys_q, keys_d;
  logic        hit_q, hit_d;
  logic        key_q, key_d;
  logic [31:0] res_q, res_d;

  logic        accept;
  logic        in_is_dma;
  logic [31:0] dec_addr;
  dec_t        dec;
  logic [31:0] rword;
  logic [31:0] rd_value;
  logic [15:0] src_half;
  logic [31:0] step;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_is_dma  = (item_i.mode == MODE_DMA16) || (item_i.mode == MODE_DMA32);
  assign step       = (mode_q == MODE_DMA16) ? 32'd2 : 32'd4;

  always_comb begin
    unique case (state_q)
      S_DRD:   dec_addr = src_q;
      S_DWR:   dec_addr = dst_q;
      default: dec_addr = in_is_dma ? item_i.dma_source : item_i.address;
    endcase
  end

  assign dec = decode(dec_addr);

  always_comb begin
    rword = hit_q ? mem_rdata_i : '0;
    if (key_q) begin
      rword[15:0] = keys_q;
    end
  end

  assign src_half = src_q[1] ? rword[31:16] : rword[15:0];

  always_comb begin
    unique case (mode_q)
      MODE_RD8:  rd_value = {24'd0, rword[8*addr_q[1:0] +: 8]};
      MODE_RD16: rd_value = {16'd0, addr_q[1] ? rword[31:16] : rword[15:0]};
      default:   rd_value = rword;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    mode_d      = mode_q;
    addr_d      = addr_q;
    src_d       = src_q;
    dst_d       = dst_q;
    cnt_d       = cnt_q;
    keys_d      = keys_q;
    hit_d       = hit_q;
    key_d       = key_q;
    res_d       = res_q;
    mem_req_o   = '0;
    res_valid_o = 1'b0;
    res_data_o  = res_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_req_o.we = 1'b1;
        mem_req_o.be = 4'hF;
        mem_req_o.row = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == ROW_W'(TOTAL_ROWS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          mode_d = item_i.mode;
          addr_d = item_i.address;
          src_d  = item_i.dma_source;
          dst_d  = item_i.dma_dest;
          cnt_d  = item_i.dma_count;
          keys_d = item_i.key_state;
          res_d  = '0;
          mem_req_o.row = dec.row;
          unique case (item_i.mode)
            MODE_RD8, MODE_RD16, MODE_RD32: begin
              mem_req_o.rd = 1'b1;
              hit_d   = dec.hit;
              key_d   = is_key_word(item_i.address);
              state_d = S_RDATA;
            end
            MODE_WR8: begin
              mem_req_o.we   = dec.hit;
              mem_req_o.be   = 4'b0001 << item_i.address[1:0];
              mem_req_o.data = {4{item_i.write_data[7:0]}};
              state_d = S_HOLD;
            end
            MODE_WR16: begin
              mem_req_o.we   = dec.hit;
              mem_req_o.be   = item_i.address[1] ? 4'b1100 : 4'b0011;
              mem_req_o.data = {2{item_i.write_data[15:0]}};
              state_d = S_HOLD;
            end
            MODE_WR32: begin
              mem_req_o.we   = dec.hit;
              mem_req_o.be   = 4'hF;
              mem_req_o.data = item_i.write_data;
              state_d = S_HOLD;
            end
            default: begin
              if (item_i.dma_count == '0) begin
                state_d = S_HOLD;
              end else begin
                mem_req_o.rd = 1'b1;
                hit_d   = dec.hit;
                key_d   = is_key_word(item_i.dma_source);
                state_d = S_DWR;
              end
            end
          endcase
        end
      end
      S_RDATA: begin
        res_valid_o = 1'b1;
        res_data_o  = rd_value;
        res_d       = rd_value;
        state_d     = res_ready_i ? S_IDLE : S_HOLD;
      end
      S_DRD: begin
        mem_req_o.rd  = 1'b1;
        mem_req_o.row = dec.row;
        hit_d   = dec.hit;
        key_d   = is_key_word(src_q);
        state_d = S_DWR;
      end
      S_DWR: begin
        mem_req_o.we  = dec.hit;
        mem_req_o.row = dec.row;
        if (mode_q == MODE_DMA16) begin
          mem_req_o.be   = dst_q[1] ? 4'b1100 : 4'b0011;
          mem_req_o.data = {2{src_half}};
        end else begin
          mem_req_o.be   = 4'hF;
          mem_req_o.data = rword;
        end
        src_d = src_q + step;
        dst_d = dst_q + step;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == 21'd1) begin
          res_d   = '0;
          state_d = S_HOLD;
        end else begin
          state_d = S_DRD;
        end
      end
      S_HOLD: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    addr_q <= addr_d;
    src_q  <= src_d;
    dst_q  <= dst_d;
    cnt_q  <= cnt_d;
    keys_q <= keys_d;
    hit_q  <= hit_d;
    key_q  <= key_d;
    res_q  <= res_d;
  end

  a_one_mem_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req_o.rd && mem_req_o.we))
    else $error("memory read and write issued together");

  a_read_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (item_i.mode == MODE_RD8 || item_i.mode == MODE_RD16 ||
                item_i.mode == MODE_RD32)) |=> (state_q == S_RDATA))
    else $error("single read did not reach the data cycle");

  a_copy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRD || state_q == S_DWR) |-> (cnt_q != '0))
    else $error("copy loop running with no units left");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> (res_valid_o && res_data_o == $past(res_data_o)))
    else $error("stalled result changed or vanished");

endmodule

`default_nettype wire

// File: rtl/core/mirrored_region_memory_bus_top.sv
// Top level of the mirrored-region memory bus: stream ports, output register, sequencer and RAM.
// A new beat is accepted only once the result beat of the last one has gone to the output
// register. A block copy moves its units one at a time, each unit a read and a write on the
// one port of the region memory.
// After reset a clearing pass writes zero to all 1327104 memory rows, one row per cycle, before
// the first beat is accepted.
`default_nettype none

module mirrored_region_memory_bus_top
  import mrmb_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // mode[2:0], address[34:3], write_data[66:35], dma_source[98:67], dma_dest[130:99],
  // dma_count[151:131], key_state[167:152]
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // read_data[31:0]
  output logic [31:0]                m_axis_tdata_o
);

  item_t       item;
  logic        res_valid;
  logic        res_ready;
  logic [31:0] res_data;
  mem_req_t    mem_req;
  logic [31:0] mem_rdata;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_data_q;

  assign item.mode       = s_axis_tdata_i[2:0];
  assign item.address    = s_axis_tdata_i[34:3];
  assign item.write_data = s_axis_tdata_i[66:35];
  assign item.dma_source = s_axis_tdata_i[98:67];
  assign item.dma_dest   = s_axis_tdata_i[130:99];
  assign item.dma_count  = s_axis_tdata_i[151:131];
  assign item.key_state  = s_axis_tdata_i[167:152];

  mrmb_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  mrmb_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready) begin
      out_valid_d = res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res_data;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire
